[rtl/go_to_goal_steering_controller_assert.svh]
// Assertion macros for the go-to-goal steering controller.
`ifndef GO_TO_GOAL_STEERING_CONTROLLER_ASSERT_SVH
`define GO_TO_GOAL_STEERING_CONTROLLER_ASSERT_SVH
`ifndef SYNTHESIS
`define G2G_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define G2G_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define G2G_ASSERT(label, clk, rst_n, prop, msg)
`define G2G_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

[rtl/g2g_pkg.sv]
`default_nettype none
package g2g_pkg;
  localparam int unsigned CordicSteps = 16;
  localparam int unsigned AngTableLen = 24;
  localparam int unsigned NumSteps = (CordicSteps > AngTableLen) ? AngTableLen : CordicSteps;
  localparam int unsigned StepW = $clog2(AngTableLen + 1);
  localparam int unsigned CordW = 28;
  localparam int unsigned ZW = 28;

  localparam logic [1:0] ActPose = 2'd0;
  localparam logic [1:0] ActTarget = 2'd1;
  localparam logic [1:0] ActTick = 2'd2;

  localparam logic [1:0] RegNearest = 2'd0;
  localparam logic [1:0] RegRadius = 2'd1;
  localparam logic [1:0] RegSpeedGain = 2'd2;
  localparam logic [1:0] RegSteerGain = 2'd3;

  localparam logic signed [ZW-1:0] HalfPiQ24 = 28'sd26353589;
  localparam logic signed [17:0] PiQ13 = 18'sd25736;
  localparam logic signed [17:0] TwoPiQ13 = 18'sd51472;
  localparam logic [15:0] KGainQ16 = 16'd39797;

  typedef enum logic [3:0] {
    StIdle, StDist, StCheck, StCordic, StMag, StOut, StHold
  } state_e;

  function automatic logic [ZW-1:0] atan_q24(input logic [StepW-1:0] i);
    logic [ZW-1:0] r;
    begin
      unique case (i)
        5'd0: r = 28'd13176795;
        5'd1: r = 28'd7778716;
        5'd2: r = 28'd4110060;
        5'd3: r = 28'd2086331;
        5'd4: r = 28'd1047214;
        5'd5: r = 28'd524117;
        5'd6: r = 28'd262123;
        5'd7: r = 28'd131069;
        default: r = (i < 5'd24) ? (28'd1 << (5'd24 - i)) : 28'd0;
      endcase
      return r;
    end
  endfunction
endpackage
`default_nettype wire

[rtl/go_to_goal_steering_controller.sv]
// Go-to-goal steering controller.
// Pose and target items are accepted back to back while idle, no result waiting.
// A control tick with both a pose and a goal passes through the distance, check,
// CORDIC, magnitude and output states, skipping CORDIC and magnitude on a catch;
// the input stalls until the result is taken, so ticks do not overlap.
// Reset clears pose, goal, list state and restores register defaults.
`default_nettype none
`include "go_to_goal_steering_controller_assert.svh"
module go_to_goal_steering_controller import g2g_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [1:0]         cfg_index_i,
  input  wire logic [14:0]        cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [1:0]         action_i,
  input  wire logic [14:0]        pos_x_i,
  input  wire logic [14:0]        pos_y_i,
  input  wire logic signed [15:0] heading_i,
  input  wire logic [7:0]         target_id_i,
  input  wire logic               first_of_list_i,
  input  wire logic               last_of_list_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [19:0]             linear_speed_o,
  output logic signed [19:0]      turn_rate_o,
  output logic                    catch_request_o,
  output logic [7:0]              caught_id_o
);
  state_e st_q, st_d;
  logic nearest_q; logic [14:0] radius_q; logic [3:0] sgain_q, tgain_q;
  logic [14:0] rx_q, ry_q, gx_q, gy_q, bx_q, by_q;
  logic signed [15:0] rh_q;
  logic [7:0] gid_q, bid_q;
  logic pose_q, goal_q, open_q;
  logic [31:0] bd_q;
  logic signed [16:0] dx_q, dy_q;
  logic [33:0] dsq_q;
  logic [29:0] r2_q;
  logic signed [CordW+16:0] mag_q;
  logic signed [ZW-1:0] zs_q;
  logic out_v_q;
  logic [19:0] spd_q; logic signed [19:0] turn_q; logic catch_q; logic [7:0] cid_q;

  logic acc, cstart, cdone;
  logic signed [CordW-1:0] cx;
  logic signed [ZW-1:0] cz;
  logic signed [16:0] ex, ey;
  logic [31:0] ed;
  logic start_el;

  assign in_ready_o = (st_q == StIdle) && !out_v_q;
  assign acc = in_valid_i && in_ready_o;
  assign ex = $signed({2'b0, pos_x_i}) - $signed({2'b0, rx_q});
  assign ey = $signed({2'b0, pos_y_i}) - $signed({2'b0, ry_q});
  assign ed = 32'(ex * ex) + 32'(ey * ey);
  assign start_el = first_of_list_i || !open_q;
  assign cstart = (st_q == StCheck) && (dsq_q > 34'(r2_q));

  g2g_cordic u_cordic (
    .clk_i(clk_i), .start_i(cstart), .dx_i(dx_q), .dy_i(dy_q),
    .done_o(cdone), .x_o(cx), .z_o(cz), .rst_ni(rst_ni)
  );

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      StIdle: if (acc && action_i == ActTick && pose_q && goal_q) st_d = StDist;
      StDist: st_d = StCheck;
      StCheck: st_d = cstart ? StCordic : StOut;
      StCordic: if (cdone) st_d = StMag;
      StMag: st_d = StOut;
      StOut: st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  // arithmetic for the output step
  logic signed [17:0] theta, diff;
  logic signed [CordW+16:0] dist_r;
  logic signed [24:0] spd_w;
  logic signed [23:0] turn_w;
  always_comb begin
    dist_r = (mag_q + (45'sd1 <<< 23)) >>> 24;
    theta = 18'((zs_q + 28'sd1024) >>> 11);
    diff = theta - 18'(rh_q);
    if (diff > PiQ13) diff = diff - TwoPiQ13;
    else if (diff < -PiQ13) diff = diff + TwoPiQ13;
    if (dist_r < 0) spd_w = '0;
    else spd_w = 25'(dist_r) * $signed({1'b0, sgain_q});
    turn_w = 24'(diff * $signed({1'b0, tgain_q}));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      nearest_q <= 1'b1; radius_q <= 15'd1024; sgain_q <= 4'd2; tgain_q <= 4'd6;
      rx_q <= '0; ry_q <= '0; rh_q <= '0; pose_q <= 1'b0;
      gx_q <= '0; gy_q <= '0; gid_q <= '0; goal_q <= 1'b0;
      bx_q <= '0; by_q <= '0; bid_q <= '0; bd_q <= '0; open_q <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          RegNearest: nearest_q <= cfg_data_i[0];
          RegRadius: radius_q <= cfg_data_i;
          RegSpeedGain: sgain_q <= cfg_data_i[3:0];
          RegSteerGain: tgain_q <= cfg_data_i[3:0];
          default: ;
        endcase
      end
      if (out_v_q && out_ready_i) out_v_q <= 1'b0;
      if (acc && action_i == ActPose) begin
        rx_q <= pos_x_i; ry_q <= pos_y_i; rh_q <= heading_i; pose_q <= 1'b1;
      end
      if (acc && action_i == ActTarget) begin
        if (nearest_q && !pose_q) begin
          open_q <= 1'b0;
        end else begin
          if (nearest_q ? (start_el || ed < bd_q) : start_el) begin
            bx_q <= pos_x_i; by_q <= pos_y_i; bid_q <= target_id_i;
            bd_q <= nearest_q ? ed : 32'd0;
          end
          open_q <= !last_of_list_i;
          if (last_of_list_i) begin
            goal_q <= 1'b1;
            if (nearest_q ? (start_el || ed < bd_q) : start_el) begin
              gx_q <= pos_x_i; gy_q <= pos_y_i; gid_q <= target_id_i;
            end else begin
              gx_q <= bx_q; gy_q <= by_q; gid_q <= bid_q;
            end
          end
        end
      end
      if (st_q == StOut) begin
        out_v_q <= 1'b1;
        if (catch_q) begin
          rx_q <= '0; ry_q <= '0; rh_q <= '0; pose_q <= 1'b0;
          gx_q <= '0; gy_q <= '0; gid_q <= '0; goal_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == StIdle) begin
      dx_q <= $signed({2'b0, gx_q}) - $signed({2'b0, rx_q});
      dy_q <= $signed({2'b0, gy_q}) - $signed({2'b0, ry_q});
    end
    if (st_q == StDist) begin
      dsq_q <= 34'(dx_q * dx_q) + 34'(dy_q * dy_q);
      r2_q <= radius_q * radius_q;
    end
    if (st_q == StCheck) begin
      catch_q <= !cstart;
      cid_q <= gid_q;
    end
    if (st_q == StCordic && cdone) begin
      mag_q <= (CordW+17)'(cx * $signed({1'b0, KGainQ16}));
      zs_q <= cz;
    end
    if (st_q == StOut) begin
      if (catch_q) begin
        spd_q <= '0; turn_q <= '0;
      end else begin
        spd_q <= (spd_w > 25'sd1048575) ? 20'hFFFFF : spd_w[19:0];
        if (turn_w > 24'sd524287) turn_q <= 20'sd524287;
        else if (turn_w < -24'sd524288) turn_q <= -20'sd524288;
        else turn_q <= turn_w[19:0];
      end
    end
  end

  assign out_valid_o = out_v_q;
  assign linear_speed_o = spd_q;
  assign turn_rate_o = turn_q;
  assign catch_request_o = catch_q;
  assign caught_id_o = catch_q ? cid_q : 8'd0;

  `G2G_ASSERT(a_ready_busy, clk_i, rst_ni, (st_q != StIdle) |-> !in_ready_o, "ready while busy")
  `G2G_ASSERT_NEXT(a_out_set, clk_i, rst_ni, st_q == StOut, out_valid_o, "result not presented")
  `G2G_ASSERT(a_catch_zero, clk_i, rst_ni, (out_valid_o && catch_request_o) |-> (linear_speed_o == 20'd0), "catch with drive")
endmodule
`default_nettype wire

[rtl/g2g_cordic.sv]
`default_nettype none
module g2g_cordic import g2g_pkg::*; (
  input  wire logic                    clk_i,
  input  wire logic                    start_i,
  input  wire logic signed [16:0]      dx_i,
  input  wire logic signed [16:0]      dy_i,
  output logic                         done_o,
  output logic signed [CordW-1:0]      x_o,
  output logic signed [ZW-1:0]         z_o,
  input  wire logic                    rst_ni
);
  logic signed [CordW-1:0] x_q, x_d, y_q, y_d, xs, ys, x0, y0;
  logic signed [ZW-1:0] z_q, z_d, z0;
  logic [StepW-1:0] i_q, i_d;
  logic busy_q, busy_d;

  always_comb begin
    x0 = CordW'(dx_i) <<< 8;
    y0 = CordW'(dy_i) <<< 8;
    z0 = '0;
    if (dx_i < 0) begin
      if (dy_i >= 0) begin
        x0 = CordW'(dy_i) <<< 8; y0 = -(CordW'(dx_i) <<< 8); z0 = HalfPiQ24;
      end else begin
        x0 = -(CordW'(dy_i) <<< 8); y0 = CordW'(dx_i) <<< 8; z0 = -HalfPiQ24;
      end
    end
    xs = x_q >>> i_q;
    ys = y_q >>> i_q;
    x_d = x_q; y_d = y_q; z_d = z_q; i_d = i_q; busy_d = busy_q;
    if (start_i) begin
      x_d = x0; y_d = y0; z_d = z0; i_d = '0; busy_d = (NumSteps != 0);
    end else if (busy_q) begin
      if (y_q >= 0) begin
        x_d = x_q + ys; y_d = y_q - xs; z_d = z_q + $signed(atan_q24(i_q));
      end else begin
        x_d = x_q - ys; y_d = y_q + xs; z_d = z_q - $signed(atan_q24(i_q));
      end
      i_d = i_q + 1'b1;
      if (i_q == StepW'(NumSteps - 1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      i_q <= '0;
    end else begin
      busy_q <= busy_d;
      i_q <= i_d;
    end
  end
  always_ff @(posedge clk_i) begin
    x_q <= x_d; y_q <= y_d; z_q <= z_d;
  end

  assign done_o = !busy_q && !start_i;
  assign x_o = x_q;
  assign z_o = z_q;
endmodule
`default_nettype wire

[dv/tb.sv]
module tb;
  import g2g_pkg::*;

  typedef struct packed {
    logic [19:0] speed;
    logic [19:0] turn;
    logic        catch_req;
    logic [7:0]  id;
  } drive_cmd_t;

  class steer_scoreboard;
    drive_cmd_t pending[$];
    int errors;
    int n_results;
    int n_catches;
    bit          nearest_mode = 1'b1;
    logic [14:0] radius = 15'd1024;
    logic [3:0]  v_gain = 4'd2;
    logic [3:0]  w_gain = 4'd6;
    logic [14:0] rx, ry;
    int          rhead;
    bit          have_pose;
    logic [14:0] gx, gy;
    logic [7:0]  gid;
    bit          have_goal;
    logic [14:0] bx, by;
    logic [7:0]  bid;
    logic [31:0] bdist;
    bit          collecting;

    function void set_reg(logic [1:0] idx, logic [14:0] val);
      case (idx)
        RegNearest:   nearest_mode = val[0];
        RegRadius:    radius = val;
        RegSpeedGain: v_gain = val[3:0];
        RegSteerGain: w_gain = val[3:0];
        default: ;
      endcase
    endfunction

    function longint shr(longint v, int s);
      return v >>> s;
    endfunction

    function void drop_pose_goal();
      rx = 0; ry = 0; rhead = 0; have_pose = 0;
      gx = 0; gy = 0; gid = 0; have_goal = 0;
    endfunction

    function void note_item(logic [1:0] act, logic [14:0] px, logic [14:0] py,
                            logic signed [15:0] hd, logic [7:0] tid, bit fst, bit lst);
      longint dx, dy, x, y, z, t, xs, ys, mag, theta, diff, spd, trn;
      longint unsigned dsq;
      logic [31:0] d;
      bit start;
      drive_cmd_t c;
      longint angles[24] = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117,
                             262123, 131069, 65536, 32768, 16384, 8192, 4096, 2048,
                             1024, 512, 256, 128, 64, 32, 16, 8, 4, 2};
      if (act == ActPose) begin
        rx = px; ry = py; rhead = hd; have_pose = 1;
        return;
      end
      if (act == ActTarget) begin
        start = fst || !collecting;
        if (nearest_mode) begin
          if (!have_pose) begin
            collecting = 0;
            return;
          end
          dx = longint'(px) - longint'(rx);
          dy = longint'(py) - longint'(ry);
          d = 32'(dx * dx + dy * dy);
          if (start || d < bdist) begin
            bx = px; by = py; bid = tid; bdist = d;
          end
        end else if (start) begin
          bx = px; by = py; bid = tid; bdist = 0;
        end
        collecting = 1;
        if (lst) begin
          gx = bx; gy = by; gid = bid; have_goal = 1; collecting = 0;
        end
        return;
      end
      if (act != ActTick || !have_pose || !have_goal) return;
      dx = longint'(gx) - longint'(rx);
      dy = longint'(gy) - longint'(ry);
      dsq = longint'(dx * dx + dy * dy);
      if (dsq <= longint'(radius) * longint'(radius)) begin
        c = '{speed: 0, turn: 0, catch_req: 1'b1, id: gid};
        pending.push_back(c);
        drop_pose_goal();
        return;
      end
      x = dx * 256; y = dy * 256; z = 0;
      if (x < 0) begin
        if (y >= 0) begin
          t = x; x = y; y = -t; z = 26353589;
        end else begin
          t = x; x = -y; y = t; z = -26353589;
        end
      end
      for (int i = 0; i < NumSteps; i++) begin
        xs = shr(x, i); ys = shr(y, i);
        if (y >= 0) begin
          x += ys; y -= xs; z += angles[i];
        end else begin
          x -= ys; y += xs; z -= angles[i];
        end
      end
      mag = shr(x * 39797 + (longint'(1) << 23), 24);
      theta = shr(z + 1024, 11);
      diff = theta - rhead;
      if (mag < 0) mag = 0;
      if (diff > 25736) diff -= 51472;
      else if (diff < -25736) diff += 51472;
      spd = mag * v_gain;
      if (spd > 1048575) spd = 1048575;
      trn = diff * w_gain;
      if (trn > 524287) trn = 524287;
      if (trn < -524288) trn = -524288;
      c = '{speed: spd[19:0], turn: trn[19:0], catch_req: 1'b0, id: 8'd0};
      pending.push_back(c);
    endfunction

    function void check_cmd(drive_cmd_t got);
      drive_cmd_t e;
      if (pending.size() == 0) begin
        $error("unexpected result speed=%0d turn=%0d", got.speed, $signed(got.turn));
        errors++;
        return;
      end
      e = pending.pop_front();
      n_results++;
      if (got.catch_req) n_catches++;
      if (got.speed !== e.speed) begin
        $error("linear_speed exp %0d got %0d", e.speed, got.speed); errors++;
      end
      if (got.turn !== e.turn) begin
        $error("turn_rate exp %0d got %0d", $signed(e.turn), $signed(got.turn)); errors++;
      end
      if (got.catch_req !== e.catch_req) begin
        $error("catch_request exp %0d got %0d", e.catch_req, got.catch_req); errors++;
      end
      if (got.id !== e.id) begin
        $error("caught_id exp %0d got %0d", e.id, got.id); errors++;
      end
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic cfg_we_i = 0;
  logic [1:0] cfg_index_i = '0;
  logic [14:0] cfg_data_i = '0;
  logic in_valid_i = 0;
  logic in_ready_o;
  logic [1:0] action_i = '0;
  logic [14:0] pos_x_i = '0, pos_y_i = '0;
  logic signed [15:0] heading_i = '0;
  logic [7:0] target_id_i = '0;
  logic first_of_list_i = 0, last_of_list_i = 0;
  logic out_valid_o;
  logic out_ready_i = 0;
  logic [19:0] linear_speed_o;
  logic signed [19:0] turn_rate_o;
  logic catch_request_o;
  logic [7:0] caught_id_o;

  go_to_goal_steering_controller DUT (.*);

  always #1 clk_i = ~clk_i;

  steer_scoreboard sb = new();
  bit calm;
  bit hold_off;
  int n_items;
  longint cycles;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 600000) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_cmd('{linear_speed_o, turn_rate_o, catch_request_o, caught_id_o});
  end

  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off) out_ready_i <= 0;
      else if (!calm && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 8);
        out_ready_i <= 0;
        repeat (gap) @(posedge clk_i);
        out_ready_i <= 1;
      end else out_ready_i <= 1;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [14:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1; cfg_index_i <= idx; cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 0;
    sb.set_reg(idx, val);
  endtask

  task automatic wait_drained();
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic send(logic [1:0] act, logic [14:0] px, logic [14:0] py,
                      logic signed [15:0] hd, logic [7:0] tid, bit fst, bit lst);
    if (!calm && $urandom_range(0, 6) == 0) begin
      in_valid_i <= 0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    in_valid_i <= 1; action_i <= act; pos_x_i <= px; pos_y_i <= py;
    heading_i <= hd; target_id_i <= tid; first_of_list_i <= fst; last_of_list_i <= lst;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_item(act, px, py, hd, tid, fst, lst);
    n_items++;
  endtask

  task automatic send_pose(logic [14:0] px, logic [14:0] py, logic signed [15:0] hd);
    send(ActPose, px, py, hd, 8'($urandom), 1'($urandom), 1'($urandom));
  endtask

  task automatic send_tick();
    send(ActTick, 15'($urandom), 15'($urandom), 16'($urandom), 8'($urandom),
         1'($urandom), 1'($urandom));
  endtask

  task automatic random_episode();
    int len;
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) begin
      send_pose(15'($urandom), 15'($urandom), 16'($signed($urandom_range(0, 51472)) - 25736));
      len = $urandom_range(1, 4);
      for (int i = 0; i < len; i++)
        send(ActTarget, 15'($urandom), 15'($urandom), 16'($urandom), 8'($urandom),
             i == 0, i == len - 1);
      send_tick();
      if ($urandom_range(0, 1)) send_tick();
    end else begin
      send(2'($urandom), 15'($urandom), 15'($urandom), 16'($urandom), 8'($urandom),
           1'($urandom), 1'($urandom));
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    send_pose(15'd0, 15'd0, 16'sd0);
    send_tick();
    send(ActTarget, 15'd32767, 15'd32767, 16'sd0, 8'd255, 1, 0);
    send(ActTarget, 15'd100, 15'd200, 16'sd0, 8'd7, 0, 0);
    send(ActTarget, 15'd100, 15'd200, 16'sd0, 8'd8, 0, 1);
    send_tick();
    send_pose(15'd32767, 15'd0, -16'sd25736);
    send(ActTarget, 15'd0, 15'd32767, 16'sd0, 8'd1, 0, 1);
    send_tick();
    send_pose(15'd20000, 15'd20000, 16'sh7fff);
    send(ActTarget, 15'd0, 15'd20000, 16'sd0, 8'd2, 1, 1);
    send_tick();
    send_pose(15'd20000, 15'd20000, 16'sh8000);
    send_tick();
    send(2'd3, 15'd5, 15'd5, 16'sd0, 8'd9, 1, 1);
    send_pose(15'd30, 15'd30, 16'sd0);
    send(ActTarget, 15'd31, 15'd30, 16'sd0, 8'd3, 1, 1);
    send_tick();
    send_tick();
    send(ActTarget, 15'd31, 15'd30, 16'sd0, 8'd4, 1, 1);
    in_valid_i <= 0;
    wait_drained();
    write_reg(RegNearest, 15'd0);
    write_reg(RegRadius, 15'd0);
    write_reg(RegSpeedGain, 15'd15);
    write_reg(RegSteerGain, 15'd15);
    send(ActTarget, 15'd10, 15'd10, 16'sd0, 8'd11, 1, 0);
    send(ActTarget, 15'd20, 15'd20, 16'sd0, 8'd12, 1, 0);
    send(ActTarget, 15'd5, 15'd5, 16'sd0, 8'd13, 0, 1);
    send_pose(15'd32767, 15'd32767, 16'sd25736);
    send_tick();
    send_pose(15'd20, 15'd20, 16'sd0);
    send_tick();
    for (int phase = 0; phase < 4; phase++) begin
      in_valid_i <= 0;
      wait_drained();
      write_reg(RegNearest, 15'($urandom_range(0, 1)));
      write_reg(RegRadius, phase == 3 ? 15'd32767 : 15'($urandom_range(0, 4000)));
      write_reg(RegSpeedGain, phase == 0 ? 15'd0 : 15'($urandom_range(0, 15)));
      write_reg(RegSteerGain, phase == 0 ? 15'd0 : 15'($urandom_range(0, 15)));
      if (phase == 1) begin
        hold_off = 1;
        fork
          begin
            repeat (300) @(posedge clk_i);
            hold_off = 0;
          end
        join_none
      end
      if (phase == 3) calm = 1;
      while (n_items < 130 + phase * 90) random_episode();
    end
    in_valid_i <= 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    $display("Run drove %0d items through 4 register settings; %0d commands checked",
             n_items, sb.n_results);
    $display("of which %0d were catch requests.", sb.n_catches);
    if (sb.errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end
endmodule
